// ===== hw/rtl/esst_pkg.sv =====
// ---------------------------------------------------------------------------
// esst_pkg
// Shared types and codes for the exponential search table block: command
// codes, the controller state type, the read address select type and the
// command and status structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
package esst_pkg;

  // Command codes carried by an input item.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE0,
    ST_CHECK0,
    ST_EXP_TEST,
    ST_EXP_CHECK,
    ST_BIN_TEST,
    ST_BIN_CHECK,
    ST_DONE
  } state_t;

  // Table read address source.
  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_BOUND,
    ADDR_MID
  } addr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      wr_entry;
    logic      load_key;
    addr_sel_t addr_sel;
    logic      init_bound;
    logic      double_bound;
    logic      init_range;
    logic      lo_up;
    logic      hi_down;
    logic      hit_zero;
    logic      hit_mid;
    logic      miss;
    logic      out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eq;
    logic lt;
    logic bound_lt_n;
    logic range_empty;
    logic mid_is_lo;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/esst_dp.sv =====
// ---------------------------------------------------------------------------
// esst_dp
// Datapath: table memory with a registered read port, key, bound and range
// registers, the entry count register and the result register.
// ---------------------------------------------------------------------------
module esst_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  esst_pkg::ctrl_t  ctrl,
  output esst_pkg::status_t status,
  input  logic [9:0]       in_entry_index,
  input  logic signed [31:0] in_value,
  input  logic             cfg_valid,
  input  logic [10:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [9:0]       out_position
);
  import esst_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  logic signed [31:0] mem [TABLE_DEPTH];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  logic signed [31:0] key_r;
  logic [NW:0]        bound_r, bound_nxt;
  logic [NW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, mid, n_r, n_nxt, n_m1;
  logic               res_found_r, res_found_nxt;
  logic [NW-1:0]      res_pos_r, res_pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [9:0]         out_position_r;

  // Entry count: zero counts as one, values above the depth saturate.
  always_comb begin
    n_nxt = n_r;
    if (cfg_valid) begin
      priority if (cfg_data == 11'd0) begin
        n_nxt = NW'(1);
      end else if (32'(cfg_data) > 32'(TABLE_DEPTH)) begin
        n_nxt = NW'(TABLE_DEPTH);
      end else begin
        n_nxt = NW'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= NW'(1);
    end else begin
      n_r <= n_nxt;
    end
  end

  // Table writes outside the depth are dropped.
  assign wr_en = ctrl.wr_entry && (32'(in_entry_index) < 32'(TABLE_DEPTH));

  // Probe midpoint, floor of the range center.
  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  assign n_m1 = n_r - NW'(1);

  always_comb begin
    unique case (ctrl.addr_sel)
      ADDR_ZERO:  rd_addr = '0;
      ADDR_BOUND: rd_addr = AW'(bound_r);
      ADDR_MID:   rd_addr = AW'(mid);
      default:    rd_addr = '0;
    endcase
  end

  // Table memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_entry_index)] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Search key.
  always_ff @(posedge clk) begin
    if (ctrl.load_key) begin
      key_r <= in_value;
    end
  end

  // Doubling bound and binary search range.
  always_comb begin
    bound_nxt = bound_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    if (ctrl.init_bound) begin
      bound_nxt = (NW+1)'(1);
    end
    if (ctrl.double_bound) begin
      bound_nxt = bound_r << 1;
    end
    if (ctrl.init_range) begin
      lo_nxt = NW'(bound_r >> 1);
      hi_nxt = (bound_r < {1'b0, n_m1}) ? NW'(bound_r) : n_m1;
    end
    if (ctrl.lo_up) begin
      lo_nxt = mid + NW'(1);
    end
    if (ctrl.hi_down) begin
      hi_nxt = mid - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    bound_r <= bound_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
  end

  // Search outcome, held until the output register is free.
  always_comb begin
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    priority if (ctrl.hit_zero) begin
      res_found_nxt = 1'b1;
      res_pos_nxt   = '0;
    end else if (ctrl.hit_mid) begin
      res_found_nxt = 1'b1;
      res_pos_nxt   = mid;
    end else if (ctrl.miss) begin
      res_found_nxt = 1'b0;
      res_pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
  end

  // Output register; a finished result waits here while new items enter.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_found_r    <= res_found_r;
      out_position_r <= 10'(res_pos_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  // Status to the controller.
  assign status.eq          = (rd_data_r == key_r);
  assign status.lt          = (rd_data_r < key_r);
  assign status.bound_lt_n  = (bound_r < {1'b0, n_r});
  assign status.range_empty = (lo_r > hi_r);
  assign status.mid_is_lo   = (mid == lo_r);
  assign status.out_busy    = out_valid_r && !out_ready;

endmodule

// ===== hw/rtl/esst_ctrl.sv =====
// ---------------------------------------------------------------------------
// esst_ctrl
// Controller: sequences the first-entry check, the doubling phase and the
// binary search, each probe an address state and a check state, then hands off the result.
// ---------------------------------------------------------------------------
module esst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  esst_pkg::status_t  status,
  output esst_pkg::ctrl_t    ctrl
);
  import esst_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_SEARCH) state_nxt = ST_PROBE0;
      end
      ST_PROBE0: state_nxt = ST_CHECK0;
      ST_CHECK0: begin
        state_nxt = status.eq ? ST_DONE : ST_EXP_TEST;
      end
      ST_EXP_TEST: begin
        state_nxt = status.bound_lt_n ? ST_EXP_CHECK : ST_BIN_TEST;
      end
      ST_EXP_CHECK: begin
        state_nxt = (status.lt || status.eq) ? ST_EXP_TEST : ST_BIN_TEST;
      end
      ST_BIN_TEST: begin
        state_nxt = status.range_empty ? ST_DONE : ST_BIN_CHECK;
      end
      ST_BIN_CHECK: begin
        priority if (status.eq) begin
          state_nxt = ST_DONE;
        end else if (status.lt) begin
          state_nxt = ST_BIN_TEST;
        end else if (status.mid_is_lo) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_BIN_TEST;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath commands.
  always_comb begin
    ctrl          = '0;
    ctrl.addr_sel = ADDR_ZERO;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.wr_entry = accept && in_cmd == CMD_WRITE;
        ctrl.load_key = accept && in_cmd == CMD_SEARCH;
      end
      ST_PROBE0: ctrl.addr_sel = ADDR_ZERO;
      ST_CHECK0: begin
        ctrl.hit_zero   = status.eq;
        ctrl.init_bound = !status.eq;
      end
      ST_EXP_TEST: begin
        ctrl.addr_sel   = ADDR_BOUND;
        ctrl.init_range = !status.bound_lt_n;
      end
      ST_EXP_CHECK: begin
        ctrl.double_bound = status.lt || status.eq;
        ctrl.init_range   = !(status.lt || status.eq);
      end
      ST_BIN_TEST: begin
        ctrl.addr_sel = ADDR_MID;
        ctrl.miss     = status.range_empty;
      end
      ST_BIN_CHECK: begin
        ctrl.addr_sel = ADDR_MID;
        priority if (status.eq) begin
          ctrl.hit_mid = 1'b1;
        end else if (status.lt) begin
          ctrl.lo_up = 1'b1;
        end else if (status.mid_is_lo) begin
          ctrl.miss = 1'b1;
        end else begin
          ctrl.hi_down = 1'b1;
        end
      end
      ST_DONE: ctrl.out_load = !status.out_busy;
      default: ctrl.addr_sel = ADDR_ZERO;
    endcase
  end

endmodule

// ===== hw/rtl/exponential_search_sorted_table_top.sv =====
// ---------------------------------------------------------------------------
// exponential_search_sorted_table_top
// Exponential search over a table of signed 32-bit entries, built from a
// controller state machine and a datapath with a one-read-port table memory.
// ---------------------------------------------------------------------------
// A write item gives no result. A search item makes one probe of the
// first entry, then doubling probes (at most log2 of the entry count)
// and then binary probes (at most log2 of the entry count plus one).
// The table's one read port sets the pace: every probe presents an
// address and then compares the registered read data. One item is worked
// on at a time, but the next item is taken while a result still waits in
// the output register. Table entries have no reset; the table must be
// written before a search reads it.
module exponential_search_sorted_table_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [9:0]         in_entry_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [9:0]         out_position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_data
);
  import esst_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // The count register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  esst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .status   (status),
    .ctrl     (ctrl)
  );

  esst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .status         (status),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_position   (out_position)
  );

  // A write item never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_WRITE |=> !$rose(out_valid))
    else $error("result appeared after a write item");

  // A search item keeps the input side closed while it runs.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_SEARCH |=> !in_ready)
    else $error("input accepted during a search");

  // The result register is only loaded when it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> !out_valid || out_ready)
    else $error("pending result overwritten");

  // A miss always reports position zero.
  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == 10'd0)
    else $error("miss with nonzero position");

endmodule
